[design/rpnsc_pkg.sv]
// ----------------------------------------------------------------------------
// rpnsc_pkg
// Shared constants, codes and types of the postfix stack calculator.
// ----------------------------------------------------------------------------
package rpnsc_pkg;

    // stack geometry
    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int LEVEL_W = 7;
    localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // operation codes
    typedef enum logic [2:0] {
        F_PUSH     = 3'd0,
        F_POP      = 3'd1,
        F_PEEK_TOP = 3'd2,
        F_PEEK_BOT = 3'd3,
        F_ADD      = 3'd4,
        F_SUB      = 3'd5,
        F_MUL      = 3'd6,
        F_DIV      = 3'd7
    } func_t;

    // status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_RANGE   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

[design/rpnsc_ram.sv]
// ----------------------------------------------------------------------------
// rpnsc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rpnsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read ports, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[design/rpnsc_div.sv]
// ----------------------------------------------------------------------------
// rpnsc_div
// Iterative signed floor divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpnsc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  rpnsc_pkg::div_req_t req,
    output rpnsc_pkg::div_rsp_t rsp
);

    localparam int W      = rpnsc_pkg::DATA_W;
    localparam int ITER_W = $clog2(W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      den_reg;
    logic              negq_reg;

    logic [W-1:0]      num_mag;
    logic [W-1:0]      den_mag;
    logic [W:0]        rem_sh;
    logic [W:0]        diff;
    logic              ge;
    logic [W-1:0]      rem_next;
    logic [W-1:0]      quo_next;

    // operand magnitudes
    assign num_mag = req.num[W-1] ? (W'(0) - req.num) : req.num;
    assign den_mag = req.den[W-1] ? (W'(0) - req.den) : req.den;

    // one restoring step
    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign diff     = rem_sh - {1'b0, den_reg};
    assign ge       = !diff[W];
    assign rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
    assign quo_next = {quo_reg[W-2:0], ge};

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            negq_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ITER_W'(W);
            rem_reg  <= '0;
            quo_reg  <= num_mag;
            den_reg  <= den_mag;
            negq_reg <= req.num[W-1] ^ req.den[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // floor correction: negate, and one less when a remainder is left
    assign rsp.done = done_reg;
    assign rsp.quot = !negq_reg ? quo_reg :
                      (rem_reg != '0) ? ~quo_reg : (W'(0) - quo_reg);

endmodule

[design/rpn_stack_calculator_unit.sv]
// Push, pop, peek, add and sub read the stack RAM on the input beat, then
// register the result; mul adds a product register, and floor divide goes
// through the 1-bit-per-cycle divider. Each beat, with its stack RAM read and
// write-back, completes first; a new beat is taken the cycle after completion.
// Reset (rst_n low, asynchronous): stack empty, no result pending; RAM contents
// are not cleared, only entries below the depth are ever used.
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit
// Bounded operand stack for postfix evaluation with add, sub, mul, floor div.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], index[37:32], zero pad
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result[31:0], depth[38:32], zero pad
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int W      = rpnsc_pkg::DATA_W;
    localparam int CNT_W  = rpnsc_pkg::CNT_W;
    localparam int ADDR_W = rpnsc_pkg::ADDR_W;
    localparam int CMP_W  = rpnsc_pkg::CMP_W;
    localparam int IDX_W  = rpnsc_pkg::INDEX_W;
    localparam int LVL_W  = rpnsc_pkg::LEVEL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    rpnsc_pkg::func_t    func_reg;
    logic [W-1:0]        value_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [W-1:0]        mul_reg;
    logic                m_valid_reg;
    logic [W-1:0]        m_result_reg;
    logic [LVL_W-1:0]    m_depth_reg;
    rpnsc_pkg::status_t  m_status_reg;

    logic                accept;
    logic                out_free;
    rpnsc_pkg::func_t    in_func;
    logic [IDX_W-1:0]    in_index;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    in_idx_ext;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    peek_top_addr;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [W-1:0]        top;
    logic [W-1:0]        second;
    logic [W-1:0]        product;
    logic                full;
    logic                few;
    logic [CNT_W-1:0]    cnt_dec;
    logic [ADDR_W-1:0]   bin_addr;

    logic                fin;
    logic [W-1:0]        fin_result;
    rpnsc_pkg::status_t  fin_status;
    logic [CNT_W-1:0]    fin_count;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [W-1:0]        wr_data;
    rpnsc_pkg::div_req_t div_req;
    rpnsc_pkg::div_rsp_t div_rsp;

    // input handshake
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign in_func       = rpnsc_pkg::func_t'(s_axis_tuser);
    assign in_index      = s_axis_tdata[37:32];

    // read addresses, issued with the input beat
    assign cnt_ext       = CMP_W'(count_reg);
    assign in_idx_ext    = CMP_W'(in_index);
    assign peek_top_addr = cnt_ext - CMP_W'(1) - in_idx_ext;
    assign cnt_dec       = count_reg - CNT_W'(1);
    assign rd_addr_b     = ADDR_W'(count_reg - CNT_W'(2));

    always_comb
    begin
        unique case (in_func)
            rpnsc_pkg::F_PEEK_TOP: rd_addr_a = peek_top_addr[ADDR_W-1:0];
            rpnsc_pkg::F_PEEK_BOT: rd_addr_a = in_idx_ext[ADDR_W-1:0];
            default:               rd_addr_a = cnt_dec[ADDR_W-1:0];
        endcase
    end

    // stack storage
    rpnsc_ram #(
        .WIDTH (W),
        .DEPTH (rpnsc_pkg::DEPTH)
    ) u_stack (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (top),
        .rd_data_b (second)
    );

    // floor divider
    rpnsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // operand checks
    assign idx_ext  = CMP_W'(index_reg);
    assign full     = (count_reg >= CNT_W'(rpnsc_pkg::DEPTH));
    assign few      = (count_reg < CNT_W'(2));
    assign bin_addr = ADDR_W'(count_reg - CNT_W'(2));
    assign product  = second * top;

    // operation sequencing and write-back
    always_comb
    begin
        state_next  = state_reg;
        fin         = 1'b0;
        fin_result  = '0;
        fin_status  = rpnsc_pkg::ST_OK;
        fin_count   = count_reg;
        wr_en       = 1'b0;
        wr_addr     = bin_addr;
        wr_data     = '0;
        div_req.start = 1'b0;
        div_req.num   = second;
        div_req.den   = top;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (func_reg)
                    rpnsc_pkg::F_PUSH:
                    begin
                        fin = out_free;
                        if (full)
                        begin
                            fin_status = rpnsc_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en     = out_free;
                            wr_addr   = count_reg[ADDR_W-1:0];
                            wr_data   = value_reg;
                            fin_count = count_reg + CNT_W'(1);
                        end
                    end
                    rpnsc_pkg::F_POP:
                    begin
                        fin = out_free;
                        if (count_reg == '0)
                        begin
                            fin_status = rpnsc_pkg::ST_FEW;
                        end
                        else
                        begin
                            fin_result = top;
                            fin_count  = cnt_dec;
                        end
                    end
                    rpnsc_pkg::F_PEEK_TOP,
                    rpnsc_pkg::F_PEEK_BOT:
                    begin
                        fin = out_free;
                        if (idx_ext >= cnt_ext)
                        begin
                            fin_status = rpnsc_pkg::ST_RANGE;
                        end
                        else
                        begin
                            fin_result = top;
                        end
                    end
                    rpnsc_pkg::F_ADD,
                    rpnsc_pkg::F_SUB:
                    begin
                        fin = out_free;
                        if (few)
                        begin
                            fin_status = rpnsc_pkg::ST_FEW;
                        end
                        else
                        begin
                            fin_result = (func_reg == rpnsc_pkg::F_ADD) ?
                                         (second + top) : (second - top);
                            wr_en      = out_free;
                            wr_data    = fin_result;
                            fin_count  = cnt_dec;
                        end
                    end
                    rpnsc_pkg::F_MUL:
                    begin
                        if (few)
                        begin
                            fin        = out_free;
                            fin_status = rpnsc_pkg::ST_FEW;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    rpnsc_pkg::F_DIV:
                    begin
                        if (few)
                        begin
                            fin        = out_free;
                            fin_status = rpnsc_pkg::ST_FEW;
                        end
                        else if (top == '0)
                        begin
                            fin        = out_free;
                            fin_status = rpnsc_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                fin        = out_free;
                fin_result = mul_reg;
                wr_en      = out_free;
                wr_data    = mul_reg;
                fin_count  = cnt_dec;
            end
            S_DIV:
            begin
                fin        = div_rsp.done && out_free;
                fin_result = div_rsp.quot;
                wr_en      = fin;
                wr_data    = div_rsp.quot;
                fin_count  = cnt_dec;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    // state, stack depth and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            func_reg     <= rpnsc_pkg::F_PUSH;
            value_reg    <= '0;
            index_reg    <= '0;
            mul_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_result_reg <= '0;
            m_depth_reg  <= '0;
            m_status_reg <= rpnsc_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                func_reg  <= in_func;
                value_reg <= s_axis_tdata[31:0];
                index_reg <= in_index;
            end
            if (state_reg == S_EXEC)
            begin
                mul_reg <= product;
            end
            if (fin)
            begin
                count_reg    <= fin_count;
                m_valid_reg  <= 1'b1;
                m_result_reg <= fin_result;
                m_depth_reg  <= LVL_W'(fin_count);
                m_status_reg <= fin_status;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output beat
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_depth_reg, m_result_reg};
    assign m_axis_tuser  = m_status_reg;

    // depth never exceeds the stack size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(rpnsc_pkg::DEPTH))
        else $error("stack depth beyond capacity");

    // the stack is only written when a result is produced
    a_wr_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> fin)
        else $error("stack write without result");

    // depth changes only with a result
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fin |=> $stable(count_reg))
        else $error("stack depth changed without result");

    // full status only on a full stack
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && fin_status == rpnsc_pkg::ST_FULL) |->
            count_reg == CNT_W'(rpnsc_pkg::DEPTH))
        else $error("full reported on a stack with room");

endmodule
